FILE: rtl/mfp_pkg.sv
// Shared types, codes and layout decoding for the market feed message parser.
`timescale 1ns / 1ps

package mfp_pkg;

  localparam int NumKinds     = 9;
  localparam int PosWidth     = 6;
  localparam int MaxMsgLen    = 34;

  localparam logic [7:0] TYPE_ADD       = 8'h41;
  localparam logic [7:0] TYPE_CONTROL   = 8'h43;
  localparam logic [7:0] TYPE_REDUCE    = 8'h44;
  localparam logic [7:0] TYPE_EXECUTION = 8'h45;
  localparam logic [7:0] TYPE_MASTER    = 8'h4C;
  localparam logic [7:0] TYPE_MODIFY    = 8'h4D;
  localparam logic [7:0] TYPE_REMOTE    = 8'h52;
  localparam logic [7:0] TYPE_PROTOCOL  = 8'h5A;

  typedef enum logic [3:0] {
    KIND_ADD       = 4'd0,
    KIND_CONTROL   = 4'd1,
    KIND_REDUCE    = 4'd2,
    KIND_EXECUTION = 4'd3,
    KIND_MASTER    = 4'd4,
    KIND_MODIFY    = 4'd5,
    KIND_REMOTE    = 4'd6,
    KIND_PROTOCOL  = 4'd7,
    KIND_UNKNOWN   = 4'd8
  } kind_e;

  typedef enum logic [3:0] {
    FLD_TIME,
    FLD_STOCK,
    FLD_FIRST,
    FLD_SECOND,
    FLD_PRICE,
    FLD_VOLUME,
    FLD_A,
    FLD_B,
    FLD_C,
    FLD_NONE
  } field_e;

  typedef struct packed {
    logic  hit;
    kind_e kind;
  } type_hit_t;

  typedef struct packed {
    field_e     field;
    logic [2:0] offset;
    logic       last;
  } seg_t;

  typedef struct packed {
    logic  en;
    kind_e kind;
  } bump_t;

  function automatic type_hit_t lookup_type(logic [7:0] b);
    type_hit_t r;
    r.hit  = 1'b1;
    r.kind = KIND_UNKNOWN;
    case (b)
      TYPE_ADD:       r.kind = KIND_ADD;
      TYPE_CONTROL:   r.kind = KIND_CONTROL;
      TYPE_REDUCE:    r.kind = KIND_REDUCE;
      TYPE_EXECUTION: r.kind = KIND_EXECUTION;
      TYPE_MASTER:    r.kind = KIND_MASTER;
      TYPE_MODIFY:    r.kind = KIND_MODIFY;
      TYPE_REMOTE:    r.kind = KIND_REMOTE;
      TYPE_PROTOCOL:  r.kind = KIND_PROTOCOL;
      default:        r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  // Maps a byte position after the type byte to its field and byte offset.
  function automatic seg_t decode_seg(kind_e kind, logic [PosWidth-1:0] pos);
    seg_t                r;
    logic [PosWidth-1:0] base;
    logic [PosWidth-1:0] last_pos;
    r.field  = FLD_NONE;
    base     = '0;
    last_pos = '0;
    case (kind)
      KIND_ADD: begin
        last_pos = 6'd26;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          [6'd10:6'd17]: begin r.field = FLD_FIRST;  base = 6'd10; end
          [6'd18:6'd21]: begin r.field = FLD_PRICE;  base = 6'd18; end
          [6'd22:6'd25]: begin r.field = FLD_VOLUME; base = 6'd22; end
          6'd26:         begin r.field = FLD_A;      base = 6'd26; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_CONTROL: begin
        last_pos = 6'd10;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          6'd10:         begin r.field = FLD_A;      base = 6'd10; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_REDUCE: begin
        last_pos = 6'd21;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          [6'd10:6'd17]: begin r.field = FLD_FIRST;  base = 6'd10; end
          [6'd18:6'd21]: begin r.field = FLD_VOLUME; base = 6'd18; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_EXECUTION: begin
        last_pos = 6'd29;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          [6'd10:6'd17]: begin r.field = FLD_FIRST;  base = 6'd10; end
          [6'd18:6'd21]: begin r.field = FLD_VOLUME; base = 6'd18; end
          [6'd22:6'd29]: begin r.field = FLD_SECOND; base = 6'd22; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_MASTER: begin
        last_pos = 6'd28;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          [6'd10:6'd17]: begin r.field = FLD_FIRST;  base = 6'd10; end
          [6'd18:6'd25]: begin r.field = FLD_SECOND; base = 6'd18; end
          6'd26:         begin r.field = FLD_A;      base = 6'd26; end
          6'd27:         begin r.field = FLD_B;      base = 6'd27; end
          6'd28:         begin r.field = FLD_C;      base = 6'd28; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_MODIFY: begin
        last_pos = 6'd33;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          [6'd10:6'd17]: begin r.field = FLD_FIRST;  base = 6'd10; end
          [6'd18:6'd25]: begin r.field = FLD_SECOND; base = 6'd18; end
          [6'd26:6'd29]: begin r.field = FLD_PRICE;  base = 6'd26; end
          [6'd30:6'd33]: begin r.field = FLD_VOLUME; base = 6'd30; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_REMOTE: begin
        last_pos = 6'd17;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd9]:   begin r.field = FLD_STOCK;  base = 6'd8;  end
          [6'd10:6'd17]: begin r.field = FLD_FIRST;  base = 6'd10; end
          default:       r.field = FLD_NONE;
        endcase
      end
      KIND_PROTOCOL: begin
        last_pos = 6'd11;
        case (pos) inside
          [6'd0:6'd7]:   begin r.field = FLD_TIME;   base = 6'd0;  end
          [6'd8:6'd11]:  begin r.field = FLD_PRICE;  base = 6'd8;  end
          default:       r.field = FLD_NONE;
        endcase
      end
      default: begin
        r.field  = FLD_NONE;
        last_pos = '0;
      end
    endcase
    r.offset = 3'(pos - base);
    r.last   = (pos >= last_pos);
    return r;
  endfunction

endpackage

FILE: rtl/mfp_counters.sv
// Saturating per-kind message counters of the market feed message parser.
`timescale 1ns / 1ps

module mfp_counters #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mfp_pkg::bump_t         bump_i,
  output logic [COUNT_WIDTH-1:0] count_o
);

  logic [COUNT_WIDTH-1:0] cnt_q [mfp_pkg::NumKinds];
  logic [COUNT_WIDTH-1:0] cur;
  logic                   in_range;

  assign in_range = (bump_i.kind <= mfp_pkg::KIND_UNKNOWN);
  assign cur      = in_range ? cnt_q[bump_i.kind] : '0;
  assign count_o  = (cur == '1) ? cur : cur + COUNT_WIDTH'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mfp_pkg::NumKinds; i++) begin
        cnt_q[i] <= '0;
      end
    end else if (bump_i.en && in_range) begin
      cnt_q[bump_i.kind] <= count_o;
    end
  end

endmodule

FILE: rtl/market_feed_message_parser.sv
// Top level of the market feed message parser: byte stream in, parsed records out.
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     in_valid_i / in_stall_o    data_byte_i
// output    out_valid_o / out_stall_i  kind_o .. kind_count_o
//
// One byte is taken per cycle while the input is not stalled. A byte passes an input
// register and is then decoded and merged into the field accumulators; the record
// that its last byte completes is written into the output register at the same time.
// Reset clears the parse state and all counters. A stalled record holds the
// pipeline, and the input stalls only while a byte waits behind that record.

module market_feed_message_parser #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  kind_o,
  output logic [63:0] timestamp_o,
  output logic [15:0] stock_id_o,
  output logic [63:0] first_id_o,
  output logic [63:0] second_id_o,
  output logic [31:0] price_or_version_o,
  output logic [31:0] volume_o,
  output logic [7:0]  byte_a_o,
  output logic [7:0]  byte_b_o,
  output logic [7:0]  byte_c_o,
  output logic [31:0] kind_count_o
);

  logic                          byte_vld_q;
  logic [7:0]                    byte_q;
  logic                          blocked;
  logic                          advance;
  logic                          in_accept;

  logic                          busy_q, busy_d;
  mfp_pkg::kind_e                kind_q, kind_d;
  logic [mfp_pkg::PosWidth-1:0]  pos_q, pos_d;
  logic [63:0]                   time_q, time_d;
  logic [15:0]                   stock_q, stock_d;
  logic [63:0]                   first_q, first_d;
  logic [63:0]                   second_q, second_d;
  logic [31:0]                   price_q, price_d;
  logic [31:0]                   volume_q, volume_d;
  logic [7:0]                    a_q, a_d;
  logic [7:0]                    b_q, b_d;
  logic [7:0]                    c_q, c_d;

  mfp_pkg::type_hit_t            hit;
  mfp_pkg::seg_t                 seg;
  logic                          emit;
  mfp_pkg::bump_t                bump;
  logic [COUNT_WIDTH-1:0]        new_count;

  logic                          out_vld_q;
  mfp_pkg::kind_e                rec_kind_q;
  logic [63:0]                   rec_time_q;
  logic [15:0]                   rec_stock_q;
  logic [63:0]                   rec_first_q;
  logic [63:0]                   rec_second_q;
  logic [31:0]                   rec_price_q;
  logic [31:0]                   rec_volume_q;
  logic [7:0]                    rec_a_q;
  logic [7:0]                    rec_b_q;
  logic [7:0]                    rec_c_q;
  logic [31:0]                   rec_count_q;

  assign blocked    = out_vld_q && out_stall_i;
  assign advance    = byte_vld_q && !blocked;
  assign in_stall_o = byte_vld_q && blocked;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
    end else if (in_accept) begin
      byte_vld_q <= 1'b1;
    end else if (advance) begin
      byte_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= data_byte_i;
    end
  end

  assign hit = mfp_pkg::lookup_type(byte_q);
  assign seg = mfp_pkg::decode_seg(kind_q, pos_q);

  always_comb begin
    busy_d   = busy_q;
    kind_d   = kind_q;
    pos_d    = pos_q;
    time_d   = time_q;
    stock_d  = stock_q;
    first_d  = first_q;
    second_d = second_q;
    price_d  = price_q;
    volume_d = volume_q;
    a_d      = a_q;
    b_d      = b_q;
    c_d      = c_q;
    emit     = 1'b0;
    if (!busy_q) begin
      time_d   = '0;
      stock_d  = '0;
      first_d  = '0;
      second_d = '0;
      price_d  = '0;
      volume_d = '0;
      a_d      = '0;
      b_d      = '0;
      c_d      = '0;
      pos_d    = '0;
      if (hit.hit) begin
        busy_d = 1'b1;
        kind_d = hit.kind;
      end else begin
        emit = 1'b1;
      end
    end else begin
      case (seg.field)
        mfp_pkg::FLD_TIME:   time_d[{seg.offset, 3'b000} +: 8] = byte_q;
        mfp_pkg::FLD_STOCK:  stock_d[{seg.offset[0], 3'b000} +: 8] = byte_q;
        mfp_pkg::FLD_FIRST:  first_d[{seg.offset, 3'b000} +: 8] = byte_q;
        mfp_pkg::FLD_SECOND: second_d[{seg.offset, 3'b000} +: 8] = byte_q;
        mfp_pkg::FLD_PRICE:  price_d[{seg.offset[1:0], 3'b000} +: 8] = byte_q;
        mfp_pkg::FLD_VOLUME: volume_d[{seg.offset[1:0], 3'b000} +: 8] = byte_q;
        mfp_pkg::FLD_A:      a_d = byte_q;
        mfp_pkg::FLD_B:      b_d = byte_q;
        mfp_pkg::FLD_C:      c_d = byte_q;
        default:             a_d = a_q;
      endcase
      if (seg.last) begin
        emit   = 1'b1;
        busy_d = 1'b0;
        pos_d  = '0;
      end else begin
        pos_d = pos_q + mfp_pkg::PosWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      kind_q <= mfp_pkg::KIND_ADD;
      pos_q  <= '0;
    end else if (advance) begin
      busy_q <= busy_d;
      kind_q <= kind_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      time_q   <= time_d;
      stock_q  <= stock_d;
      first_q  <= first_d;
      second_q <= second_d;
      price_q  <= price_d;
      volume_q <= volume_d;
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
    end
  end

  assign bump.en   = advance && emit;
  assign bump.kind = busy_q ? kind_q : mfp_pkg::KIND_UNKNOWN;

  mfp_counters #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_counters (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .bump_i  (bump),
    .count_o (new_count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (bump.en) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bump.en) begin
      rec_kind_q   <= bump.kind;
      rec_time_q   <= time_d;
      rec_stock_q  <= stock_d;
      rec_first_q  <= first_d;
      rec_second_q <= second_d;
      rec_price_q  <= price_d;
      rec_volume_q <= volume_d;
      rec_a_q      <= busy_q ? a_d : byte_q;
      rec_b_q      <= b_d;
      rec_c_q      <= c_d;
      rec_count_q  <= 32'(new_count);
    end
  end

  assign out_valid_o        = out_vld_q;
  assign kind_o             = rec_kind_q;
  assign timestamp_o        = rec_time_q;
  assign stock_id_o         = rec_stock_q;
  assign first_id_o         = rec_first_q;
  assign second_id_o        = rec_second_q;
  assign price_or_version_o = rec_price_q;
  assign volume_o           = rec_volume_q;
  assign byte_a_o           = rec_a_q;
  assign byte_b_o           = rec_b_q;
  assign byte_c_o           = rec_c_q;
  assign kind_count_o       = rec_count_q;

  a_idle_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> pos_q == '0)
    else $error("Parse position is not zero while awaiting a type byte.");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> pos_q < mfp_pkg::PosWidth'(mfp_pkg::MaxMsgLen))
    else $error("Parse position ran past the longest message.");

  a_unknown_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && rec_kind_q == mfp_pkg::KIND_UNKNOWN |->
      rec_time_q == '0 && rec_first_q == '0 && rec_b_q == '0)
    else $error("Unknown-type record carries message data.");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> rec_count_q != '0)
    else $error("Record count does not include the record itself.");

  a_record_after_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bump.en |=> out_vld_q && rec_kind_q == $past(bump.kind))
    else $error("Emitted record did not reach the output register.");

endmodule

FILE: tb/sv/feed_record_checker.sv
// Checker for the market feed message parser: predicts each record and compares it.
`timescale 1ns / 1ps

module feed_record_checker
  import mfp_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [3:0]  kind_o,
  input  logic [63:0] timestamp_o,
  input  logic [15:0] stock_id_o,
  input  logic [63:0] first_id_o,
  input  logic [63:0] second_id_o,
  input  logic [31:0] price_or_version_o,
  input  logic [31:0] volume_o,
  input  logic [7:0]  byte_a_o,
  input  logic [7:0]  byte_b_o,
  input  logic [7:0]  byte_c_o,
  input  logic [31:0] kind_count_o,
  output int          mismatches_o,
  output int          waiting_o,
  output int          records_o,
  output int          unknowns_o
);

  typedef struct packed {
    kind_e       kind;
    logic [63:0] timestamp;
    logic [15:0] stock_id;
    logic [63:0] first_id;
    logic [63:0] second_id;
    logic [31:0] price;
    logic [31:0] volume;
    logic [7:0]  byte_a;
    logic [7:0]  byte_b;
    logic [7:0]  byte_c;
    logic [31:0] count;
  } feed_record_t;

  localparam logic [7:0] TypeByte [8] = '{
    TYPE_ADD, TYPE_CONTROL, TYPE_REDUCE, TYPE_EXECUTION,
    TYPE_MASTER, TYPE_MODIFY, TYPE_REMOTE, TYPE_PROTOCOL
  };

  // Field order and byte lengths of each message body; a zero length ends the list.
  localparam field_e BodyField [8][7] = '{
    '{FLD_TIME, FLD_STOCK, FLD_FIRST, FLD_PRICE, FLD_VOLUME, FLD_A, FLD_NONE},
    '{FLD_TIME, FLD_STOCK, FLD_A, FLD_NONE, FLD_NONE, FLD_NONE, FLD_NONE},
    '{FLD_TIME, FLD_STOCK, FLD_FIRST, FLD_VOLUME, FLD_NONE, FLD_NONE, FLD_NONE},
    '{FLD_TIME, FLD_STOCK, FLD_FIRST, FLD_VOLUME, FLD_SECOND, FLD_NONE, FLD_NONE},
    '{FLD_TIME, FLD_STOCK, FLD_FIRST, FLD_SECOND, FLD_A, FLD_B, FLD_C},
    '{FLD_TIME, FLD_STOCK, FLD_FIRST, FLD_SECOND, FLD_PRICE, FLD_VOLUME, FLD_NONE},
    '{FLD_TIME, FLD_STOCK, FLD_FIRST, FLD_NONE, FLD_NONE, FLD_NONE, FLD_NONE},
    '{FLD_TIME, FLD_PRICE, FLD_NONE, FLD_NONE, FLD_NONE, FLD_NONE, FLD_NONE}
  };

  localparam int BodyLen [8][7] = '{
    '{8, 2, 8, 4, 4, 1, 0},
    '{8, 2, 1, 0, 0, 0, 0},
    '{8, 2, 8, 4, 0, 0, 0},
    '{8, 2, 8, 4, 8, 0, 0},
    '{8, 2, 8, 8, 1, 1, 1},
    '{8, 2, 8, 8, 4, 4, 0},
    '{8, 2, 8, 0, 0, 0, 0},
    '{8, 4, 0, 0, 0, 0, 0}
  };

  logic                   msg_open;
  kind_e                  msg_kind;
  int                     body_pos;
  logic [63:0]            acc_time;
  logic [15:0]            acc_stock;
  logic [63:0]            acc_first;
  logic [63:0]            acc_second;
  logic [31:0]            acc_price;
  logic [31:0]            acc_volume;
  logic [7:0]             acc_a;
  logic [7:0]             acc_b;
  logic [7:0]             acc_c;
  logic [COUNT_WIDTH-1:0] kind_totals [NumKinds];
  feed_record_t           expected_records [$];
  int                     mismatch_total;
  int                     record_total;
  int                     unknown_total;

  function automatic void clear_accumulators();
    acc_time   = '0;
    acc_stock  = '0;
    acc_first  = '0;
    acc_second = '0;
    acc_price  = '0;
    acc_volume = '0;
    acc_a      = '0;
    acc_b      = '0;
    acc_c      = '0;
  endfunction

  function automatic logic [31:0] bump_total(kind_e k);
    if (kind_totals[int'(k)] != '1) begin
      kind_totals[int'(k)] = kind_totals[int'(k)] + 1'b1;
    end
    return 32'(kind_totals[int'(k)]);
  endfunction

  function automatic void queue_record(kind_e k);
    feed_record_t r;
    r.kind      = k;
    r.timestamp = acc_time;
    r.stock_id  = acc_stock;
    r.first_id  = acc_first;
    r.second_id = acc_second;
    r.price     = acc_price;
    r.volume    = acc_volume;
    r.byte_a    = acc_a;
    r.byte_b    = acc_b;
    r.byte_c    = acc_c;
    r.count     = bump_total(k);
    expected_records.push_back(r);
  endfunction

  function automatic void deposit_byte(field_e f, int offset, logic [7:0] b);
    logic [63:0] v;
    v = 64'(b) << (8 * (offset % 8));
    case (f)
      FLD_TIME:   acc_time   = acc_time | v;
      FLD_STOCK:  acc_stock  = acc_stock | v[15:0];
      FLD_FIRST:  acc_first  = acc_first | v;
      FLD_SECOND: acc_second = acc_second | v;
      FLD_PRICE:  acc_price  = acc_price | v[31:0];
      FLD_VOLUME: acc_volume = acc_volume | v[31:0];
      FLD_A:      acc_a      = b;
      FLD_B:      acc_b      = b;
      default:    acc_c      = b;
    endcase
  endfunction

  function automatic void parse_feed_byte(logic [7:0] b);
    int    total;
    int    len;
    logic  found;
    if (!msg_open) begin
      clear_accumulators();
      body_pos = 0;
      found    = 1'b0;
      for (int k = 0; k < 8; k++) begin
        if (!found && TypeByte[k] == b) begin
          found    = 1'b1;
          msg_kind = kind_e'(k);
        end
      end
      if (found) begin
        msg_open = 1'b1;
      end else begin
        acc_a = b;
        queue_record(KIND_UNKNOWN);
        acc_a = '0;
      end
    end else begin
      total = 0;
      for (int s = 0; s < 7; s++) begin
        len = BodyLen[int'(msg_kind)][s];
        if (len != 0 && body_pos >= total && body_pos < total + len) begin
          deposit_byte(BodyField[int'(msg_kind)][s], body_pos - total, b);
        end
        total += len;
      end
      body_pos++;
      if (body_pos >= total) begin
        queue_record(msg_kind);
        msg_open = 1'b0;
        body_pos = 0;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      mismatch_total++;
    end
  endfunction

  function automatic void check_record();
    feed_record_t r;
    if (expected_records.size() == 0) begin
      $display("%0t: record of kind %0d arrived with none expected", $time, kind_o);
      mismatch_total++;
    end else begin
      r = expected_records.pop_front();
      check_field("kind", 64'(r.kind), 64'(kind_o));
      check_field("timestamp", r.timestamp, timestamp_o);
      check_field("stock_id", 64'(r.stock_id), 64'(stock_id_o));
      check_field("first_id", r.first_id, first_id_o);
      check_field("second_id", r.second_id, second_id_o);
      check_field("price_or_version", 64'(r.price), 64'(price_or_version_o));
      check_field("volume", 64'(r.volume), 64'(volume_o));
      check_field("byte_a", 64'(r.byte_a), 64'(byte_a_o));
      check_field("byte_b", 64'(r.byte_b), 64'(byte_b_o));
      check_field("byte_c", 64'(r.byte_c), 64'(byte_c_o));
      check_field("kind_count", 64'(r.count), 64'(kind_count_o));
      if (r.kind == KIND_UNKNOWN) begin
        unknown_total++;
      end
    end
    record_total++;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_open = 1'b0;
      msg_kind = KIND_UNKNOWN;
      body_pos = 0;
      clear_accumulators();
      for (int k = 0; k < NumKinds; k++) begin
        kind_totals[k] = '0;
      end
      expected_records.delete();
      mismatch_total = 0;
      record_total   = 0;
      unknown_total  = 0;
      mismatches_o  <= 0;
      waiting_o     <= 0;
      records_o     <= 0;
      unknowns_o    <= 0;
    end else begin
      // A record on the output side is compared before this edge's byte is
      // predicted, so it can never match a record queued at the same edge.
      if (out_valid_o && !out_stall_i) begin
        check_record();
      end
      if (in_valid_i && !in_stall_o) begin
        parse_feed_byte(data_byte_i);
      end
      mismatches_o <= mismatch_total;
      waiting_o    <= expected_records.size();
      records_o    <= record_total;
      unknowns_o   <= unknown_total;
    end
  end

endmodule

FILE: tb/sv/market_feed_message_parser_tb.sv
// Top of the market feed message parser testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module market_feed_message_parser_tb;
  import mfp_pkg::*;

  localparam int CountWidth  = 32;
  localparam int RandomBytes = 1530;
  localparam int CycleLimit  = 100000;

  typedef enum int {
    FILL_ZERO,
    FILL_ONES,
    FILL_RANDOM
  } fill_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [3:0]  kind_o;
  logic [63:0] timestamp_o;
  logic [15:0] stock_id_o;
  logic [63:0] first_id_o;
  logic [63:0] second_id_o;
  logic [31:0] price_or_version_o;
  logic [31:0] volume_o;
  logic [7:0]  byte_a_o;
  logic [7:0]  byte_b_o;
  logic [7:0]  byte_c_o;
  logic [31:0] kind_count_o;

  int          mismatch_total;
  int          records_waiting;
  int          record_total;
  int          unknown_total;
  int          bytes_sent     = 0;
  int          directed_bytes = 0;
  int          cycle_count    = 0;
  logic        quiet          = 1'b0;

  market_feed_message_parser #(
    .COUNT_WIDTH(CountWidth)
  ) dut (
    .*
  );

  feed_record_checker #(
    .COUNT_WIDTH(CountWidth)
  ) u_check (
    .*,
    .mismatches_o(mismatch_total),
    .waiting_o   (records_waiting),
    .records_o   (record_total),
    .unknowns_o  (unknown_total)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("%0t: run did not finish within %0d cycles", $time, CycleLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(99) < 6);
  end

  function automatic logic [7:0] type_byte(kind_e k);
    case (k)
      KIND_ADD:       return TYPE_ADD;
      KIND_CONTROL:   return TYPE_CONTROL;
      KIND_REDUCE:    return TYPE_REDUCE;
      KIND_EXECUTION: return TYPE_EXECUTION;
      KIND_MASTER:    return TYPE_MASTER;
      KIND_MODIFY:    return TYPE_MODIFY;
      KIND_REMOTE:    return TYPE_REMOTE;
      default:        return TYPE_PROTOCOL;
    endcase
  endfunction

  function automatic int body_length(kind_e k);
    case (k)
      KIND_ADD:       return 27;
      KIND_CONTROL:   return 11;
      KIND_REDUCE:    return 22;
      KIND_EXECUTION: return 30;
      KIND_MASTER:    return 29;
      KIND_MODIFY:    return 34;
      KIND_REMOTE:    return 18;
      default:        return 12;
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while (!quiet && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
    end
    bytes_sent++;
  endtask

  task automatic send_message(input kind_e k, input fill_e fill, input int cut);
    int n;
    n = body_length(k) - cut;
    send_byte(type_byte(k));
    for (int i = 0; i < n; i++) begin
      case (fill)
        FILL_ZERO: send_byte(8'h00);
        FILL_ONES: send_byte(8'hFF);
        default:   send_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  // Uppercase letters that name a type become lowercase, which no type uses.
  task automatic send_unknown();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    for (int k = 0; k < 8; k++) begin
      if (type_byte(kind_e'(k)) == b) begin
        b = b ^ 8'h20;
      end
    end
    send_byte(b);
  endtask

  initial begin
    kind_e k;
    int    pick;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 8; i++) begin
      send_message(kind_e'(i), FILL_ZERO, 0);
      send_message(kind_e'(i), FILL_ONES, 0);
    end
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h61);
    send_byte(8'h40);
    send_byte(8'h5B);
    send_message(KIND_MASTER, FILL_RANDOM, 0);
    directed_bytes = bytes_sent;

    // Mostly complete messages with random content, with unknown bytes between
    // them; cut messages knock the parser out of step with the message boundaries.
    while (bytes_sent < directed_bytes + RandomBytes) begin
      quiet = (bytes_sent >= directed_bytes + 800) && (bytes_sent < directed_bytes + 1300);
      pick  = $urandom_range(99);
      k     = kind_e'($urandom_range(7));
      if (pick < 10) begin
        send_unknown();
      end else if (pick < 15) begin
        send_message(k, FILL_RANDOM, $urandom_range(body_length(k) - 1, 1));
      end else begin
        send_message(k, FILL_RANDOM, 0);
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (records_waiting != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);

    $display("Sent %0d feed bytes, %0d of them in directed messages of every type.",
             bytes_sent, directed_bytes);
    $display("Compared %0d parsed records, %0d of them from unknown type bytes.",
             record_total, unknown_total);
    if (mismatch_total == 0 && records_waiting == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
